>>> design/gnds_pkg.sv
// ----------------------------------------------------------------------------
// gnds_pkg: shared constants and types for the grouped neighbour distance sum
// Widths of the stream fields, memory geometry and the controller command set.
// ----------------------------------------------------------------------------
package gnds_pkg;

  localparam int unsigned MaxVars     = 32;
  localparam int unsigned NumFeatures = 9;
  localparam int unsigned LabelW      = 6;
  localparam int unsigned FeatW       = 16;
  localparam int unsigned SlotW       = $clog2(MaxVars);
  localparam int unsigned FIdxW       = $clog2(NumFeatures);
  localparam int unsigned AccW        = 36;
  // sum of squares: 9 * 65535^2 < 2^36
  localparam int unsigned SumW        = 36;
  // radicand = sum << 16
  localparam int unsigned RadW        = SumW + 16;
  localparam int unsigned RootW       = RadW / 2;
  localparam int unsigned RootCntW    = $clog2(RootW + 1);
  localparam int unsigned InTdataW    = 160;
  localparam int unsigned OutTdataW   = 40;

  localparam logic [AccW-1:0] AccMax = '1;

  // controller to datapath
  typedef struct packed {
    logic             load;       // capture input word
    logic             sel_col;    // 0: row memory, 1: column memory
    logic             clr_sum;    // clear sum of squares
    logic             mem_rd;     // read one stored feature
    logic             sq_add;     // add squared difference of read feature
    logic             mem_wr;     // write one feature
    logic [FIdxW-1:0] fidx;
    logic             root_start;
    logic             root_step;
    logic             acc_add;    // add root into total
    logic             clr_total;
    logic             out_load;   // move total into output register
  } gnds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_hit;
    logic col_hit;
    logic row_seen;
    logic col_seen;
    logic last;
    logic root_done;
  } gnds_sts_t;

endpackage

>>> design/gnds_datapath.sv
// ----------------------------------------------------------------------------
// gnds_datapath: feature memories, squared-distance accumulation, root unit
// Two feature memories, seen marks, a bit-pair square root and the total.
// ----------------------------------------------------------------------------
module gnds_datapath import gnds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LabelW-1:0]    num_vars_i,
  input  logic [InTdataW-1:0]  in_data_i,
  input  logic                 in_last_i,
  input  gnds_cmd_t            cmd_i,
  output gnds_sts_t            sts_o,
  output logic [AccW-1:0]      total_o
);

  localparam int unsigned Depth = MaxVars * NumFeatures;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [FeatW-1:0]  feat_q [NumFeatures];
  logic [LabelW-1:0] rl_q, cl_q;
  logic              last_q;
  logic [MaxVars-1:0] row_seen_q, col_seen_q;
  logic [FeatW-1:0]  row_mem [Depth];
  logic [FeatW-1:0]  col_mem [Depth];
  logic [FeatW-1:0]  rd_q;
  logic [FIdxW-1:0]  rd_idx_q;
  logic [SumW-1:0]   sum_q;
  logic [RadW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [RootCntW-1:0] cnt_q;
  logic [AccW-1:0]   acc_q, total_q;

  logic [LabelW-1:0] nv;
  logic [SlotW-1:0]  rslot, cslot, slot;
  logic              row_hit, col_hit;
  logic [AddrW-1:0]  addr;
  logic signed [FeatW:0] diff;
  logic [FeatW-1:0]      absd;
  logic [2*FeatW-1:0]    sq;
  logic [RadW+1:0]   trial;
  logic [RadW+1:0]   rem_sh;
  logic [AccW:0]     acc_sum;

  assign nv = (num_vars_i > LabelW'(MaxVars)) ? LabelW'(MaxVars) : num_vars_i;
  assign row_hit = (rl_q >= LabelW'(1)) && ({1'b0, rl_q} + 7'd2 <= {1'b0, nv});
  assign col_hit = (cl_q >= LabelW'(3)) && (cl_q <= nv);
  assign rslot = SlotW'(rl_q - LabelW'(1));
  assign cslot = SlotW'(cl_q - LabelW'(1));
  assign slot  = cmd_i.sel_col ? cslot : rslot;
  assign addr  = AddrW'(slot) * AddrW'(NumFeatures) + AddrW'(cmd_i.fidx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < NumFeatures; k++) begin
        feat_q[k] <= in_data_i[12 + k*FeatW +: FeatW];
      end
      rl_q   <= in_data_i[0 +: LabelW];
      cl_q   <= in_data_i[LabelW +: LabelW];
      last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q     <= cmd_i.sel_col ? col_mem[addr] : row_mem[addr];
      rd_idx_q <= cmd_i.fidx;
    end
    if (cmd_i.mem_wr && !cmd_i.sel_col) begin
      row_mem[addr] <= feat_q[cmd_i.fidx];
    end
    if (cmd_i.mem_wr && cmd_i.sel_col) begin
      col_mem[addr] <= feat_q[cmd_i.fidx];
    end
  end

  // rd_idx_q names the feature held in rd_q
  assign diff = $signed({1'b0, feat_q[rd_idx_q]}) - $signed({1'b0, rd_q});
  assign absd = diff[FeatW] ? FeatW'(-diff) : diff[FeatW-1:0];
  assign sq   = absd * absd;

  // restoring root: two radicand bits per step
  assign rem_sh = {rem_q, sum_q[SumW-1 -: 2]} ;
  assign trial  = (RadW+2)'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_seen_q <= '0;
      col_seen_q <= '0;
      acc_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.mem_wr && cmd_i.fidx == FIdxW'(NumFeatures - 1)) begin
        if (cmd_i.sel_col) col_seen_q[cslot] <= 1'b1;
        else               row_seen_q[rslot] <= 1'b1;
      end
      if (cmd_i.acc_add) begin
        acc_q <= acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];
      end
      if (cmd_i.clr_total) begin
        acc_q      <= '0;
        row_seen_q <= '0;
        col_seen_q <= '0;
      end
      if (cmd_i.root_start)     cnt_q <= RootCntW'(RootW);
      else if (cmd_i.root_step) cnt_q <= cnt_q - RootCntW'(1);
    end
  end

  assign acc_sum = {1'b0, acc_q} + {1'b0, AccW'(root_q)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_sum) begin
      sum_q <= '0;
    end else if (cmd_i.sq_add) begin
      sum_q <= sum_q + SumW'(sq);
    end else if (cmd_i.root_start) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      // sum_q shifts out its top two bits; low 16 radicand bits are zero
      sum_q <= {sum_q[SumW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= RadW'(rem_sh - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= RadW'(rem_sh);
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      total_q <= acc_q;
    end
  end

  assign sts_o.row_hit   = row_hit;
  assign sts_o.col_hit   = col_hit;
  assign sts_o.row_seen  = row_seen_q[rslot];
  assign sts_o.col_seen  = col_seen_q[cslot];
  assign sts_o.last      = last_q;
  assign sts_o.root_done = (cnt_q == RootCntW'(1));
  assign total_o         = total_q;

endmodule

>>> design/gnds_ctrl.sv
// ----------------------------------------------------------------------------
// gnds_ctrl: sequencer for one row word
// Walks the row group then the column group: for a seen slot read/square, root,
// accumulate; store in every hit group; then emits the total on a last row.
// ----------------------------------------------------------------------------
module gnds_ctrl import gnds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gnds_sts_t sts_i,
  output gnds_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StGroup = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StRoot  = 3'd3;
  localparam logic [2:0] StAcc   = 3'd4;
  localparam logic [2:0] StWrite = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic             col_q, col_d;
  logic [FIdxW:0]   idx_q, idx_d;   // read phase runs one past the last feature
  logic             ovld_q, ovld_d;
  logic             hit, seen;

  assign hit  = col_q ? sts_i.col_hit : sts_i.row_hit;
  assign seen = col_q ? sts_i.col_seen : sts_i.row_seen;
  assign in_ready_o  = (state_q == StIdle) && (!ovld_q || out_ready_i);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    idx_d   = idx_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.sel_col = col_q;
    cmd_o.fidx    = FIdxW'(idx_q);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          col_d      = 1'b0;
          state_d    = StGroup;
        end
      end
      StGroup: begin
        idx_d         = '0;
        cmd_o.clr_sum = 1'b1;
        if (!hit) begin
          if (col_q) state_d = StDone;
          else       col_d   = 1'b1;
        end else if (seen) begin
          state_d = StRead;
        end else begin
          state_d = StWrite;
        end
      end
      StRead: begin
        // square of the feature read last cycle is added while the next is read
        if (idx_q != '0) begin
          cmd_o.sq_add = 1'b1;
        end
        if (idx_q == (FIdxW+1)'(NumFeatures)) begin
          state_d = StAcc;
          idx_d   = '0;
        end else begin
          cmd_o.mem_rd = 1'b1;
          idx_d        = idx_q + 1'b1;
        end
      end
      StAcc: begin
        // first pass: start root; idx used as phase flag
        if (idx_q == '0) begin
          cmd_o.root_start = 1'b1;
          idx_d            = (FIdxW+1)'(1);
          state_d          = StRoot;
        end else begin
          cmd_o.acc_add = 1'b1;
          idx_d         = '0;
          state_d       = StWrite;
        end
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) state_d = StAcc;
      end
      StWrite: begin
        cmd_o.mem_wr = 1'b1;
        if (idx_q == (FIdxW+1)'(NumFeatures - 1)) begin
          idx_d = '0;
          if (col_q) begin
            state_d = StDone;
          end else begin
            col_d   = 1'b1;
            state_d = StGroup;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDone: begin
        if (sts_i.last) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.clr_total = 1'b1;
          ovld_d          = 1'b1;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= 1'b0;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

>>> design/grouped_neighbour_distance_sum_top.sv
// ----------------------------------------------------------------------------
// grouped_neighbour_distance_sum_top: neighbour distance total per matrix
// Rows come in as stream words; on the last row the saturated total goes out.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        labels + 9 features, tlast = last_row
// m_axis    out  tvalid/tready        total_distance (36 bits)
// cfg       in   cfg_we_i (no stall)  num_vars (6 bits)
//
// Steps: a word with no label hit passes idle, two group checks and done; each
// group that hits adds a write of the 9 features, and a seen group also reads
// and squares them, accumulates and runs a 26-step bit-pair square root (the
// root unit sets the rate). A new word is taken only back in idle.
// Reset clears seen marks, running total and control; feature memories and the output register are not reset.
// A waiting result blocks a new word only until m_axis_tready is seen.
// ----------------------------------------------------------------------------
module grouped_neighbour_distance_sum_top import gnds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LabelW-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // row_label[5:0], col_label[11:6], feat_0..feat_8[155:12], zero fill
  input  logic [InTdataW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // total_distance[35:0], zero fill
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic [LabelW-1:0] num_vars_q;
  gnds_cmd_t         cmd;
  gnds_sts_t         sts;
  logic [AccW-1:0]   total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q <= LabelW'(32);
    end else if (cfg_we_i) begin
      num_vars_q <= cfg_wdata_i;
    end
  end

  gnds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gnds_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .num_vars_i (num_vars_q),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .total_o    (total)
  );

  assign m_axis_tdata = {{(OutTdataW-AccW){1'b0}}, total};

  // no new word while a root is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.root_step |-> !s_axis_tready) else $error("accepted during root");

  // result only follows a load of the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load)) else $error("spurious result");

  // memory write and read never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.mem_wr && cmd.mem_rd)) else $error("memory port conflict");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for grouped_neighbour_distance_sum_top
// Streams matrix rows with random gaps and output stalls, predicts each
// matrix total with a behavioral model and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gnds_pkg::*;

  typedef logic [FeatW-1:0] feat_vec_t [NumFeatures];

  // Behavioral model of the block plus queue of expected totals.
  class total_scoreboard;
    int unsigned        n_vars;
    feat_vec_t          row_mem [MaxVars];
    feat_vec_t          col_mem [MaxVars];
    bit                 row_seen [MaxVars];
    bit                 col_seen [MaxVars];
    logic [AccW-1:0]    acc;
    logic [AccW-1:0]    totals_q [$];
    int                 errors;

    function new();
      n_vars = 32;
      acc = '0;
      errors = 0;
      foreach (row_seen[i]) begin
        row_seen[i] = 0;
        col_seen[i] = 0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void add_distance(feat_vec_t a, feat_vec_t b);
      logic [63:0] sq;
      logic [63:0] s;
      longint      d;
      sq = 0;
      for (int k = 0; k < NumFeatures; k++) begin
        d = longint'(a[k]) - longint'(b[k]);
        sq += 64'(d * d);
      end
      s = 64'(acc) + int_sqrt(sq << 16);
      acc = (s > 64'(AccMax)) ? AccMax : s[AccW-1:0];
    endfunction

    function void note_row(int unsigned rl, int unsigned cl, feat_vec_t f, bit last);
      int unsigned nv;
      nv = (n_vars > MaxVars) ? MaxVars : n_vars;
      if (rl >= 1 && rl + 2 <= nv) begin
        if (row_seen[rl-1]) add_distance(f, row_mem[rl-1]);
        row_mem[rl-1] = f;
        row_seen[rl-1] = 1;
      end
      if (cl >= 3 && cl <= nv) begin
        if (col_seen[cl-1]) add_distance(f, col_mem[cl-1]);
        col_mem[cl-1] = f;
        col_seen[cl-1] = 1;
      end
      if (last) begin
        totals_q = {totals_q, acc};
        acc = '0;
        foreach (row_seen[i]) begin
          row_seen[i] = 0;
          col_seen[i] = 0;
        end
      end
    endfunction

    task check_total(logic [OutTdataW-1:0] word);
      logic [AccW-1:0] want;
      if (totals_q.size() == 0) begin
        report_mismatch($sformatf("unexpected total %0h", word));
        return;
      end
      want = totals_q.pop_front();
      if (word[AccW-1:0] !== want)
        report_mismatch($sformatf("total got %0h want %0h", word[AccW-1:0], want));
      if (word[OutTdataW-1:AccW] !== '0)
        report_mismatch($sformatf("fill bits set %0h", word));
    endtask
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 cfg_we_i = 0;
  logic [LabelW-1:0]    cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tlast = 0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [OutTdataW-1:0] m_axis_tdata;

  total_scoreboard sb = new();
  bit  calm = 0;     // no idling while set
  bit  stim_done = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  grouped_neighbour_distance_sum_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // one register write while idle
  task automatic set_num_vars(int unsigned nv);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= LabelW'(nv);
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.n_vars = nv;
  endtask

  // drive one row word, with optional random idle before it; valid stays
  // high afterwards until the next idle cycle or drain()
  task automatic send_row(int unsigned rl, int unsigned cl, feat_vec_t f, bit last);
    logic [InTdataW-1:0] w;
    w = '0;
    w[5:0] = LabelW'(rl);
    w[11:6] = LabelW'(cl);
    for (int k = 0; k < NumFeatures; k++) w[12 + k*FeatW +: FeatW] = f[k];
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= w;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_row(rl, cl, f, last);
    @(negedge clk_i);
  endtask

  function automatic feat_vec_t rand_feats(int mode);
    feat_vec_t f;
    for (int k = 0; k < NumFeatures; k++)
      case (mode)
        0: f[k] = 16'h0000;
        1: f[k] = 16'hFFFF;
        default: f[k] = 16'($urandom);
      endcase
    return f;
  endfunction

  task automatic drain();
    int n;
    n = 0;
    s_axis_tvalid <= 0;
    while (sb.totals_q.size() != 0 && n < 200000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (150) @(negedge clk_i);  // block may still be busy on a row
  endtask

  // output side: random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_total(m_axis_tdata);
  end

  initial begin
    int unsigned nv;
    int unsigned rl;
    int unsigned cl;
    int unsigned rows;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: extreme features, out-of-range labels, last row alone
    send_row(1, 3, rand_feats(0), 0);
    send_row(1, 3, rand_feats(1), 0);
    send_row(30, 32, rand_feats(0), 0);
    send_row(30, 32, rand_feats(1), 0);
    send_row(0, 0, rand_feats(2), 0);
    send_row(31, 2, rand_feats(2), 0);
    send_row(63, 63, rand_feats(2), 0);
    send_row(33, 33, rand_feats(2), 0);
    send_row(1, 3, rand_feats(0), 1);
    send_row(5, 7, rand_feats(2), 1);          // last row with first visits
    // many maximal distances in one matrix
    for (int i = 0; i < 24; i++) send_row(1 + (i % 2) * 0, 3, rand_feats(i % 2), i == 23);
    drain();

    // several settings: extremes first, then random
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: nv = 3;
        1: nv = 0;
        2: nv = 63;
        3: nv = 4;
        4: nv = 32;
        default: nv = $urandom_range(63);
      endcase
      set_num_vars(nv);
      calm = (ph == 2);
      for (int m = 0; m < 10; m++) begin
        rows = $urandom_range(15, 2);
        for (int r = 0; r < rows; r++) begin
          if ($urandom_range(9) < 8) begin
            rl = $urandom_range((nv > 4 ? (nv > 32 ? 32 : nv) : 4) - 2, 1);
            cl = $urandom_range(nv < 3 ? 3 : (nv > 32 ? 32 : nv), 3);
            if ($urandom_range(3) == 0) rl = $urandom_range(3, 1);
          end else begin
            rl = $urandom_range(63);
            cl = $urandom_range(63);
          end
          send_row(rl, cl, rand_feats($urandom_range(9) == 0 ? $urandom_range(1) : 2),
                   r == rows - 1);
        end
      end
      calm = 0;
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0 && sb.totals_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
